FILE: rtl/decimating_sample_capture_fifo_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimating sample capture FIFO
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMATING_SAMPLE_CAPTURE_FIFO_CORE_ASSERT_SVH
`define DECIMATING_SAMPLE_CAPTURE_FIFO_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSCF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dscf_pkg.sv
// ----------------------------------------------------------------------------
// dscf_pkg
// Types and constants shared by the capture FIFO controller and datapath.
// ----------------------------------------------------------------------------
package dscf_pkg;

	localparam logic [2:0] MODE_CAPTURE = 3'd0;
	localparam logic [2:0] MODE_PUBLISH = 3'd1;
	localparam logic [2:0] MODE_DRAIN   = 3'd2;
	localparam logic [2:0] MODE_START   = 3'd3;
	localparam logic [2:0] MODE_STOP    = 3'd4;

	localparam logic REG_FIELD_SELECT = 1'b0;
	localparam logic REG_DECIMATION   = 1'b1;

	localparam int SEL_TIME    = 0;
	localparam int SEL_A       = 1;
	localparam int SEL_B       = 2;
	localparam int SEL_C       = 3;
	localparam int SEL_APPLIED = 4;
	localparam int SEL_ENCODER = 5;
	localparam int SEL_ROTOR   = 6;

	localparam logic [6:0]  FIELD_SELECT_RESET = 7'd127;
	localparam logic [15:0] DECIMATION_RESET   = 16'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic [31:0] serial;
		logic [23:0] a;
		logic [23:0] b;
		logic [15:0] applied;
		logic [15:0] measured;
		logic [15:0] rotor;
	} slot_t;

	typedef struct packed {
		logic accept;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic drain_go;
	} sts_t;

endpackage

FILE: rtl/decimating_sample_capture_fifo_core.sv
// An item that returns no sample is shown in the cycle after it is accepted.
// A drain that returns a sample goes through ST_LOAD for the registered ring read.
// Throughput: one item per cycle unless a result is stalled or a drain is in ST_LOAD.
// Reset: arst_n clears pointers, counters and angles and resets configuration to defaults.
// The sample ring is not cleared; only written entries can ever be drained.
// ----------------------------------------------------------------------------
// decimating_sample_capture_fifo_core
// Decimating telemetry capture FIFO with a drop-on-full sample ring.
// ----------------------------------------------------------------------------
module decimating_sample_capture_fifo_core #(
	parameter int RING_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          mode,
	input  logic signed [23:0]  phase_a_current,
	input  logic signed [23:0]  phase_b_current,
	input  logic [15:0]         applied_angle_in,
	input  logic [15:0]         measured_angle_in,
	input  logic                measured_angle_ok,
	input  logic [15:0]         rotor_angle_in,
	input  logic                tx_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                sample_valid,
	output logic [31:0]         sample_number,
	output logic signed [23:0]  out_phase_a,
	output logic signed [23:0]  out_phase_b,
	output logic signed [25:0]  out_phase_c,
	output logic [15:0]         out_applied_angle,
	output logic [15:0]         out_measured_angle,
	output logic [15:0]         out_rotor_angle,
	output logic [6:0]          fields_present,
	output logic [31:0]         lost_total,
	output logic [31:0]         sent_total,
	output logic                running_flag
);
	import dscf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	dscf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dscf_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.mode               (mode),
		.phase_a_current    (phase_a_current),
		.phase_b_current    (phase_b_current),
		.applied_angle_in   (applied_angle_in),
		.measured_angle_in  (measured_angle_in),
		.measured_angle_ok  (measured_angle_ok),
		.rotor_angle_in     (rotor_angle_in),
		.tx_ready           (tx_ready),
		.sample_valid       (sample_valid),
		.sample_number      (sample_number),
		.out_phase_a        (out_phase_a),
		.out_phase_b        (out_phase_b),
		.out_phase_c        (out_phase_c),
		.out_applied_angle  (out_applied_angle),
		.out_measured_angle (out_measured_angle),
		.out_rotor_angle    (out_rotor_angle),
		.fields_present     (fields_present),
		.lost_total         (lost_total),
		.sent_total         (sent_total),
		.running_flag       (running_flag)
	);

endmodule

FILE: rtl/dscf_ctrl.sv
// ----------------------------------------------------------------------------
// dscf_ctrl
// Handshake controller: accepts items, sequences drain reads, owns out_valid.
// ----------------------------------------------------------------------------
`include "decimating_sample_capture_fifo_core_assert.svh"

module dscf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  dscf_pkg::sts_t sts,
	output dscf_pkg::cmd_t cmd
);
	import dscf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		cmd         = '0;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				in_stall   = out_valid_q && out_stall;
				cmd.accept = in_valid && !in_stall;
				if (cmd.accept) begin
					if (sts.drain_go) begin
						state_d = ST_LOAD;
					end else begin
						out_valid_d = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				cmd.finish  = 1'b1;
				out_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`DSCF_ASSERT_SAME(a_load_out_free, state_q == ST_LOAD, !out_valid_q,
		"Drain data landed while the output register was occupied.")
	`DSCF_ASSERT_SAME(a_busy_stalls, state_q != ST_IDLE, in_stall,
		"Input transfer possible while a drain is in progress.")
	`DSCF_ASSERT_NEXT(a_load_one_cycle, state_q == ST_LOAD, state_q == ST_IDLE && out_valid_q,
		"Drain did not complete in one cycle.")

endmodule

FILE: rtl/dscf_datapath.sv
// ----------------------------------------------------------------------------
// dscf_datapath
// Sample ring, pointers, counters, decimation, held angles, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
`include "decimating_sample_capture_fifo_core_assert.svh"

module dscf_datapath #(
	parameter int RING_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dscf_pkg::cmd_t      cmd,
	output dscf_pkg::sts_t      sts,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	input  logic [2:0]          mode,
	input  logic signed [23:0]  phase_a_current,
	input  logic signed [23:0]  phase_b_current,
	input  logic [15:0]         applied_angle_in,
	input  logic [15:0]         measured_angle_in,
	input  logic                measured_angle_ok,
	input  logic [15:0]         rotor_angle_in,
	input  logic                tx_ready,
	output logic                sample_valid,
	output logic [31:0]         sample_number,
	output logic signed [23:0]  out_phase_a,
	output logic signed [23:0]  out_phase_b,
	output logic signed [25:0]  out_phase_c,
	output logic [15:0]         out_applied_angle,
	output logic [15:0]         out_measured_angle,
	output logic [15:0]         out_rotor_angle,
	output logic [6:0]          fields_present,
	output logic [31:0]         lost_total,
	output logic [31:0]         sent_total,
	output logic                running_flag
);
	import dscf_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	slot_t mem [RING_DEPTH];
	slot_t rd_q;
	slot_t wr_slot;
	logic  wr_en;

	logic [6:0]       fs_q;
	logic [15:0]      dec_q;
	logic [PTR_W-1:0] put_q, put_d, take_q, take_d, put_nxt, take_nxt;
	logic [31:0]      lost_q, lost_d, sent_q, sent_d, serial_q, serial_d;
	logic             en_q, en_d;
	logic [15:0]      cnt_q, cnt_d;
	logic [15:0]      hold_app_q, hold_app_d, hold_meas_q, hold_meas_d;
	logic             cfg_wr;
	logic             load;
	logic [25:0]      phase_c;

	assign put_nxt  = (put_q == PTR_LAST) ? '0 : put_q + 1'b1;
	assign take_nxt = (take_q == PTR_LAST) ? '0 : take_q + 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == REG_DECIMATION) ? {16'd0, dec_q} : {25'd0, fs_q};
	assign sts.drain_go = (mode == MODE_DRAIN) && (take_q != put_q) && tx_ready;

	always_comb begin
		put_d       = put_q;
		take_d      = take_q;
		lost_d      = lost_q;
		sent_d      = sent_q;
		serial_d    = serial_q;
		en_d        = en_q;
		cnt_d       = cnt_q;
		hold_app_d  = hold_app_q;
		hold_meas_d = hold_meas_q;
		wr_en       = 1'b0;
		if (cmd.accept) begin
			case (mode)
				MODE_CAPTURE: begin
					if (en_q) begin
						if (cnt_q > 16'd1) begin
							cnt_d = cnt_q - 16'd1;
						end else begin
							cnt_d = dec_q;
							if (put_nxt == take_q) begin
								lost_d = lost_q + 32'd1;
							end else begin
								if (fs_q[SEL_ENCODER] && measured_angle_ok) begin
									hold_meas_d = measured_angle_in;
								end
								serial_d = serial_q + 32'd1;
								wr_en    = 1'b1;
								put_d    = put_nxt;
							end
						end
					end
				end
				MODE_PUBLISH: begin
					hold_app_d  = applied_angle_in;
					hold_meas_d = measured_angle_in;
				end
				MODE_START: begin
					take_d = put_q;
					lost_d = '0;
					sent_d = '0;
					cnt_d  = dec_q;
					en_d   = 1'b1;
				end
				MODE_STOP: begin
					en_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			take_d = take_nxt;
			sent_d = sent_q + 32'd1;
		end
	end

	always_comb begin
		wr_slot.serial   = serial_q + 32'd1;
		wr_slot.a        = phase_a_current;
		wr_slot.b        = phase_b_current;
		wr_slot.applied  = hold_app_q;
		wr_slot.measured = hold_meas_d;
		wr_slot.rotor    = rotor_angle_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q        <= FIELD_SELECT_RESET;
			dec_q       <= DECIMATION_RESET;
			put_q       <= '0;
			take_q      <= '0;
			lost_q      <= '0;
			sent_q      <= '0;
			serial_q    <= '0;
			en_q        <= 1'b0;
			cnt_q       <= DECIMATION_RESET;
			hold_app_q  <= '0;
			hold_meas_q <= '0;
		end else begin
			put_q       <= put_d;
			take_q      <= take_d;
			lost_q      <= lost_d;
			sent_q      <= sent_d;
			serial_q    <= serial_d;
			en_q        <= en_d;
			cnt_q       <= cnt_d;
			hold_app_q  <= hold_app_d;
			hold_meas_q <= hold_meas_d;
			if (cfg_wr && paddr[2] == REG_FIELD_SELECT && pwdata[6:0] != 7'd0) begin
				fs_q <= pwdata[6:0];
			end
			if (cfg_wr && paddr[2] == REG_DECIMATION) begin
				dec_q <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[put_q] <= wr_slot;
		end
		rd_q <= mem[take_q];
	end

	assign load    = (cmd.accept && !sts.drain_go) || cmd.finish;
	assign phase_c = -({{2{rd_q.a[23]}}, rd_q.a} + {{2{rd_q.b[23]}}, rd_q.b});

	always_ff @(posedge clk) begin
		if (load) begin
			sample_valid       <= cmd.finish;
			sample_number      <= (cmd.finish && fs_q[SEL_TIME]) ? rd_q.serial : '0;
			out_phase_a        <= (cmd.finish && fs_q[SEL_A]) ? $signed(rd_q.a) : '0;
			out_phase_b        <= (cmd.finish && fs_q[SEL_B]) ? $signed(rd_q.b) : '0;
			out_phase_c        <= (cmd.finish && fs_q[SEL_C]) ? $signed(phase_c) : '0;
			out_applied_angle  <= (cmd.finish && fs_q[SEL_APPLIED]) ? rd_q.applied : '0;
			out_measured_angle <= (cmd.finish && fs_q[SEL_ENCODER]) ? rd_q.measured : '0;
			out_rotor_angle    <= (cmd.finish && fs_q[SEL_ROTOR]) ? rd_q.rotor : '0;
			fields_present     <= fs_q;
			lost_total         <= lost_d;
			sent_total         <= sent_d;
			running_flag       <= en_d;
		end
	end

	`DSCF_ASSERT_SAME(a_put_in_range, 1'b1, put_q <= PTR_LAST,
		"Put pointer left the ring.")
	`DSCF_ASSERT_SAME(a_take_in_range, 1'b1, take_q <= PTR_LAST,
		"Take pointer left the ring.")
	`DSCF_ASSERT_SAME(a_drain_not_empty, cmd.finish, take_q != put_q,
		"Drain completed on an empty ring.")

endmodule

FILE: tb/sv/sample_fifo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_fifo_checker
// Watches register writes and both item channels of the capture FIFO. Every
// input transfer is run through a local model of the ring, the decimation
// counter and the statistics counters, and each result transfer is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module sample_fifo_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [23:0] phase_a_current,
	input  logic [23:0] phase_b_current,
	input  logic [15:0] applied_angle_in,
	input  logic [15:0] measured_angle_in,
	input  logic        measured_angle_ok,
	input  logic [15:0] rotor_angle_in,
	input  logic        tx_ready,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        sample_valid,
	input  logic [31:0] sample_number,
	input  logic [23:0] out_phase_a,
	input  logic [23:0] out_phase_b,
	input  logic [25:0] out_phase_c,
	input  logic [15:0] out_applied_angle,
	input  logic [15:0] out_measured_angle,
	input  logic [15:0] out_rotor_angle,
	input  logic [6:0]  fields_present,
	input  logic [31:0] lost_total,
	input  logic [31:0] sent_total,
	input  logic        running_flag,
	output int          mismatch_count,
	output int          pending_results
);
	import dscf_pkg::*;

	localparam int RING_SLOTS = 256;
	localparam int PTR_W = $clog2(RING_SLOTS);
	localparam logic [2:0] ADDR_FIELD_SELECT = {REG_FIELD_SELECT, 2'b00};
	localparam logic [2:0] ADDR_DECIMATION   = {REG_DECIMATION, 2'b00};

	typedef struct packed {
		logic [2:0]  mode;
		logic [23:0] a;
		logic [23:0] b;
		logic [15:0] applied;
		logic [15:0] measured;
		logic        measured_ok;
		logic [15:0] rotor;
		logic        tx_ready;
	} capture_op_t;

	typedef struct packed {
		logic        sample_valid;
		logic [31:0] number;
		logic [23:0] a;
		logic [23:0] b;
		logic [25:0] c;
		logic [15:0] applied;
		logic [15:0] measured;
		logic [15:0] rotor;
		logic [6:0]  fields;
		logic [31:0] lost;
		logic [31:0] sent;
		logic        running;
	} telemetry_result_t;

	slot_t             sample_ring [RING_SLOTS];
	logic [PTR_W-1:0]  put_ptr;
	logic [PTR_W-1:0]  take_ptr;
	logic [31:0]       lost_cnt;
	logic [31:0]       sent_cnt;
	logic              capture_on;
	logic [15:0]       countdown;
	logic [15:0]       held_applied;
	logic [15:0]       held_measured;
	logic [31:0]       serial_cnt;
	logic [6:0]        sel_mask;
	logic [15:0]       decim;
	telemetry_result_t expected_results [$];

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic predict_result(input capture_op_t op, output telemetry_result_t res);
		logic [PTR_W-1:0] next_ptr;
		slot_t            s;
		int               sa;
		int               sb;
		int               sc;
		res = '0;
		case (op.mode)
			MODE_CAPTURE: begin
				if (capture_on) begin
					if (countdown > 16'd1) begin
						countdown = countdown - 16'd1;
					end else begin
						countdown = decim;
						next_ptr = put_ptr + 1'b1;
						if (next_ptr == take_ptr) begin
							lost_cnt = lost_cnt + 32'd1;
						end else begin
							if (sel_mask[SEL_ENCODER] && op.measured_ok)
								held_measured = op.measured;
							serial_cnt = serial_cnt + 32'd1;
							s.serial   = serial_cnt;
							s.a        = op.a;
							s.b        = op.b;
							s.applied  = held_applied;
							s.measured = held_measured;
							s.rotor    = op.rotor;
							sample_ring[put_ptr] = s;
							put_ptr = next_ptr;
						end
					end
				end
			end
			MODE_PUBLISH: begin
				held_applied  = op.applied;
				held_measured = op.measured;
			end
			MODE_DRAIN: begin
				if (take_ptr != put_ptr && op.tx_ready) begin
					s = sample_ring[take_ptr];
					take_ptr = take_ptr + 1'b1;
					sent_cnt = sent_cnt + 32'd1;
					sa = {{8{s.a[23]}}, s.a};
					sb = {{8{s.b[23]}}, s.b};
					sc = -(sa + sb);
					res.sample_valid = 1'b1;
					if (sel_mask[SEL_TIME])    res.number   = s.serial;
					if (sel_mask[SEL_A])       res.a        = s.a;
					if (sel_mask[SEL_B])       res.b        = s.b;
					if (sel_mask[SEL_C])       res.c        = sc[25:0];
					if (sel_mask[SEL_APPLIED]) res.applied  = s.applied;
					if (sel_mask[SEL_ENCODER]) res.measured = s.measured;
					if (sel_mask[SEL_ROTOR])   res.rotor    = s.rotor;
				end
			end
			MODE_START: begin
				take_ptr   = put_ptr;
				lost_cnt   = '0;
				sent_cnt   = '0;
				countdown  = decim;
				capture_on = 1'b1;
			end
			MODE_STOP: begin
				capture_on = 1'b0;
			end
			default: begin
			end
		endcase
		res.fields  = sel_mask;
		res.lost    = lost_cnt;
		res.sent    = sent_cnt;
		res.running = capture_on;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		capture_op_t       op;
		telemetry_result_t want;
		telemetry_result_t got;
		if (!arst_n) begin
			put_ptr         = '0;
			take_ptr        = '0;
			lost_cnt        = '0;
			sent_cnt        = '0;
			capture_on      = 1'b0;
			countdown       = DECIMATION_RESET;
			held_applied    = '0;
			held_measured   = '0;
			serial_cnt      = '0;
			sel_mask        = FIELD_SELECT_RESET;
			decim           = DECIMATION_RESET;
			mismatch_count  = 0;
			pending_results = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_FIELD_SELECT && pwdata[6:0] != 7'd0)
					sel_mask = pwdata[6:0];
				if (paddr == ADDR_DECIMATION)
					decim = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no prediction waiting");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("sample_valid", 32'(want.sample_valid), 32'(sample_valid));
					check_field("sample_number", want.number, sample_number);
					check_field("out_phase_a", 32'(want.a), 32'(out_phase_a));
					check_field("out_phase_b", 32'(want.b), 32'(out_phase_b));
					check_field("out_phase_c", 32'(want.c), 32'(out_phase_c));
					check_field("out_applied_angle", 32'(want.applied),
						32'(out_applied_angle));
					check_field("out_measured_angle", 32'(want.measured),
						32'(out_measured_angle));
					check_field("out_rotor_angle", 32'(want.rotor), 32'(out_rotor_angle));
					check_field("fields_present", 32'(want.fields), 32'(fields_present));
					check_field("lost_total", want.lost, lost_total);
					check_field("sent_total", want.sent, sent_total);
					check_field("running_flag", 32'(want.running), 32'(running_flag));
				end
			end
			if (in_valid && !in_stall) begin
				op.mode        = mode;
				op.a           = phase_a_current;
				op.b           = phase_b_current;
				op.applied     = applied_angle_in;
				op.measured    = measured_angle_in;
				op.measured_ok = measured_angle_ok;
				op.rotor       = rotor_angle_in;
				op.tx_ready    = tx_ready;
				predict_result(op, got);
				expected_results.push_back(got);
			end
			pending_results = expected_results.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the decimating sample capture FIFO. A short
// directed sequence is followed by random phases under several register
// settings, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	import dscf_pkg::*;

	localparam logic [2:0] ADDR_FIELD_SELECT = {REG_FIELD_SELECT, 2'b00};
	localparam logic [2:0] ADDR_DECIMATION   = {REG_DECIMATION, 2'b00};
	localparam logic [2:0] MODE_SPARE_LO     = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI     = 3'd7;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_NORMAL} op_mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [23:0] phase_a_current = '0;
	logic [23:0] phase_b_current = '0;
	logic [15:0] applied_angle_in = '0;
	logic [15:0] measured_angle_in = '0;
	logic        measured_angle_ok = 1'b0;
	logic [15:0] rotor_angle_in = '0;
	logic        tx_ready = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        sample_valid;
	logic [31:0] sample_number;
	logic signed [23:0] out_phase_a;
	logic signed [23:0] out_phase_b;
	logic signed [25:0] out_phase_c;
	logic [15:0] out_applied_angle;
	logic [15:0] out_measured_angle;
	logic [15:0] out_rotor_angle;
	logic [6:0]  fields_present;
	logic [31:0] lost_total;
	logic [31:0] sent_total;
	logic        running_flag;
	int          mismatch_count;
	int          pending_results;

	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	decimating_sample_capture_fifo_core dut (.*);

	sample_fifo_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : receiver
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = steady ? 0 : $urandom_range(0, MAX_GAP);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	function automatic logic [23:0] rand_current();
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			default: return 24'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	function automatic logic [2:0] pick_mode(input op_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 90) return MODE_CAPTURE;
				if (r < 95) return MODE_DRAIN;
				return MODE_PUBLISH;
			end
			MIX_DRAIN: begin
				if (r < 70) return MODE_DRAIN;
				if (r < 90) return MODE_CAPTURE;
				if (r < 96) return MODE_PUBLISH;
				return MODE_STOP;
			end
			default: begin
				if (r < 45) return MODE_CAPTURE;
				if (r < 78) return MODE_DRAIN;
				if (r < 86) return MODE_PUBLISH;
				if (r < 90) return MODE_START;
				if (r < 95) return MODE_STOP;
				return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			end
		endcase
	endfunction

	task automatic send_op(input logic [2:0] m, input logic [23:0] a, input logic [23:0] b,
			input logic [15:0] app, input logic [15:0] meas, input logic ok,
			input logic [15:0] rot, input logic tx);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode              <= m;
		phase_a_current   <= a;
		phase_b_current   <= b;
		applied_angle_in  <= app;
		measured_angle_in <= meas;
		measured_angle_ok <= ok;
		rotor_angle_in    <= rot;
		tx_ready          <= tx;
		in_valid          <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_mode(input logic [2:0] m);
		send_op(m, rand_current(), rand_current(), 16'($urandom_range(0, 16'hFFFF)),
			16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
			16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 99) < 85);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic config_regs(input logic [6:0] fs, input logic [15:0] dec);
		logic [31:0] word;
		word = $urandom;
		word[6:0] = fs;
		apb_write(ADDR_FIELD_SELECT, word);
		word = $urandom;
		word[15:0] = dec;
		apb_write(ADDR_DECIMATION, word);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [6:0] fs, input logic [15:0] dec, input int count,
			input op_mix_t mix, input bit no_idle, input bit pressure);
		int          done;
		logic [2:0]  m;
		settle();
		steady = no_idle;
		config_regs(fs, dec);
		if (mix != MIX_DRAIN)
			send_mode(MODE_START);
		if (pressure)
			hold_req = 1'b1;
		done = 0;
		while (done < count) begin
			m = pick_mode(mix);
			send_mode(m);
			if (m <= MODE_STOP)
				done++;
		end
	endtask

	initial begin : stimulus
		int k;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		config_regs(FIELD_SELECT_RESET, 16'd1);

		send_op(MODE_DRAIN, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b1);
		send_op(MODE_CAPTURE, 24'h123456, 24'h654321, 16'h0, 16'h1111, 1'b1, 16'h2222, 1'b1);
		send_op(MODE_PUBLISH, 24'h0, 24'h0, 16'hFFFF, 16'h0000, 1'b0, 16'h0, 1'b0);
		send_op(MODE_START, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0);
		send_op(MODE_CAPTURE, 24'h7FFFFF, 24'h7FFFFF, 16'h0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
		send_op(MODE_CAPTURE, 24'h800000, 24'h800000, 16'hFFFF, 16'h1234, 1'b0, 16'h0, 1'b1);
		send_op(MODE_CAPTURE, 24'h800000, 24'h7FFFFF, 16'h0, 16'h0, 1'b1, 16'h8000, 1'b1);
		send_op(MODE_DRAIN, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0);
		repeat (4) send_op(MODE_DRAIN, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			16'hFFFF, 1'b1);
		for (k = MODE_SPARE_LO; k <= MODE_SPARE_HI; k++)
			send_mode(3'(k));
		send_op(MODE_PUBLISH, 24'h0, 24'h0, 16'h0000, 16'hFFFF, 1'b1, 16'h0, 1'b1);
		send_op(MODE_START, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0);
		send_op(MODE_CAPTURE, 24'h000001, 24'hFFFFFF, 16'h0, 16'h5555, 1'b1, 16'hAAAA, 1'b1);
		send_op(MODE_CAPTURE, 24'h400000, 24'h400000, 16'h0, 16'hAAAA, 1'b0, 16'h5555, 1'b1);
		send_op(MODE_STOP, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0);
		send_op(MODE_CAPTURE, 24'h111111, 24'h222222, 16'h0, 16'h3333, 1'b1, 16'h4444, 1'b1);
		send_op(MODE_PUBLISH, 24'h0, 24'h0, 16'h7777, 16'h8888, 1'b0, 16'h0, 1'b0);
		send_op(MODE_DRAIN, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b1);
		send_op(MODE_DRAIN, 24'h0, 24'h0, 16'h0, 16'h0, 1'b0, 16'h0, 1'b1);

		run_phase(7'h7F, 16'd1, 320, MIX_FILL, 1'b0, 1'b0);
		run_phase(7'h01, 16'd0, 200, MIX_DRAIN, 1'b0, 1'b0);
		run_phase(7'h2A, 16'd2, 200, MIX_NORMAL, 1'b0, 1'b1);
		run_phase(7'h00, 16'hFFFF, 120, MIX_NORMAL, 1'b0, 1'b0);
		run_phase(7'h55, 16'd3, 200, MIX_NORMAL, 1'b1, 1'b0);
		run_phase(7'($urandom_range(1, 127)), 16'($urandom_range(1, 8)), 100, MIX_NORMAL,
			1'b0, 1'b0);
		run_phase(7'h40, 16'd1, 300, MIX_FILL, 1'b0, 1'b0);
		run_phase(7'h7F, 16'd32, 100, MIX_NORMAL, 1'b0, 1'b0);
		settle();

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
